// ----- rtl/lfd_pkg.sv -----
// shared types for the length-prefixed frame deframer
// no dependencies
`default_nettype none

package lfd_pkg;

	localparam int unsigned BYTE_W = 8;

	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_LENGTH = 6'b000010,
		PH_STX    = 6'b000100,
		PH_DATA   = 6'b001000,
		PH_ETX    = 6'b010000,
		PH_EOT    = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		REG_SOH = 2'd0,
		REG_STX = 2'd1,
		REG_ETX = 2'd2,
		REG_EOT = 2'd3
	} reg_index_t;

	localparam logic KIND_PAYLOAD  = 1'b0;
	localparam logic KIND_COMPLETE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] soh;
		logic [BYTE_W-1:0] stx;
		logic [BYTE_W-1:0] etx;
		logic [BYTE_W-1:0] eot;
	} codes_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] payload_byte;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/lfd_cfg.sv -----
// code byte registers written through the plain write port
// depends on lfd_pkg
`default_nettype none

module lfd_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output lfd_pkg::codes_t        codes
);

	lfd_pkg::codes_t codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.soh <= 8'd1;
			codes_q.stx <= 8'd2;
			codes_q.etx <= 8'd3;
			codes_q.eot <= 8'd4;
		end else if (cfg_we) begin
			unique case (lfd_pkg::reg_index_t'(cfg_index))
				lfd_pkg::REG_SOH: codes_q.soh <= cfg_data;
				lfd_pkg::REG_STX: codes_q.stx <= cfg_data;
				lfd_pkg::REG_ETX: codes_q.etx <= cfg_data;
				lfd_pkg::REG_EOT: codes_q.eot <= cfg_data;
				default: codes_q <= codes_q;
			endcase
		end
	end

	assign codes = codes_q;

endmodule

`default_nettype wire

// ----- rtl/lfd_parse.sv -----
// frame phase tracking and result generation for payload beats and frame completion
// depends on lfd_pkg
`default_nettype none

module lfd_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        rx_byte,
	input  wire lfd_pkg::codes_t   codes,
	output logic                   res_valid,
	output lfd_pkg::result_t       res
);

	lfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      length_q, length_d;
	logic [7:0]      count_q, count_d;
	logic [7:0]      count_inc;

	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		length_d  = length_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			lfd_pkg::PH_LENGTH: begin
				length_d = rx_byte;
				count_d  = 8'd0;
				phase_d  = lfd_pkg::PH_STX;
			end
			lfd_pkg::PH_STX: begin
				if (rx_byte == codes.stx)
					phase_d = (length_q == 8'd0) ? lfd_pkg::PH_ETX : lfd_pkg::PH_DATA;
			end
			lfd_pkg::PH_DATA: begin
				res_valid         = 1'b1;
				res.kind          = lfd_pkg::KIND_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = count_q;
				res.frame_length  = length_q;
				count_d           = count_inc;
				if (count_inc == length_q)
					phase_d = lfd_pkg::PH_ETX;
			end
			lfd_pkg::PH_ETX: begin
				if (rx_byte == codes.etx)
					phase_d = lfd_pkg::PH_EOT;
			end
			lfd_pkg::PH_EOT: begin
				if (rx_byte == codes.eot) begin
					res_valid        = 1'b1;
					res.kind         = lfd_pkg::KIND_COMPLETE;
					res.frame_length = length_q;
					phase_d          = lfd_pkg::PH_HUNT;
					length_d         = 8'd0;
					count_d          = 8'd0;
				end
			end
			default: begin
				// hunting, and any stray phase code
				if (rx_byte == codes.soh) begin
					phase_d = lfd_pkg::PH_LENGTH;
					count_d = 8'd0;
				end else begin
					phase_d = lfd_pkg::PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lfd_pkg::PH_HUNT;
			length_q <= 8'd0;
			count_q  <= 8'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			count_q  <= count_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lfd_obuf.sv -----
// output register with skid stage for result beats
// depends on lfd_pkg
`default_nettype none

module lfd_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire lfd_pkg::result_t  in_res,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lfd_pkg::result_t       out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	lfd_pkg::result_t out_q;
	lfd_pkg::result_t skid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_frame_deframer_unit.sv -----
// length-prefixed frame deframer, top level
// depends on lfd_pkg, lfd_cfg, lfd_parse, lfd_obuf
// a result beat passes through the output register, or its skid stage, before it appears on the master side
// throughput: one input beat per cycle while the skid stage is empty; the frame phase update is one short step
// a two-entry output register with skid stage keeps input flowing while a result waits
// reset: async active low; phase returns to hunting, code registers to 1, 2, 3, 4
`default_nettype none

module length_prefixed_frame_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // payload_byte, payload_index, frame_length
	output logic             m_tuser,   // result_kind
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	lfd_pkg::codes_t  codes;
	lfd_pkg::result_t res;
	lfd_pkg::result_t out_res;
	logic             res_valid;
	logic             accept;

	assign accept = s_tvalid && s_tready;

	lfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	lfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_tdata),
		.codes     (codes),
		.res_valid (res_valid),
		.res       (res)
	);

	lfd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept && res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.frame_length, out_res.payload_index, out_res.payload_byte};
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire
